### design/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg: shared constants and types for the rectangular/polar converter
// Angle and gain formats, arctangent table, operation codes, stage control.
// ----------------------------------------------------------------------------
package rpc_pkg;

   // result fields are fixed at 20 bits, two's complement
   localparam int RESULT_WIDTH = 20;

   // angles inside the CORDIC are degrees with 16 fraction bits
   localparam int ANGLE_FRAC  = 16;
   localparam int ANGLE_WIDTH = 26;

   // gain compensation K in Q30
   localparam int               GAIN_FRAC   = 30;
   localparam logic [29:0]      CORDIC_GAIN = 30'd652032874;

   localparam int QUARTER_TURN_DEG       = 90;
   localparam int HALF_TURN_DEG          = 180;
   localparam int THREE_QUARTER_TURN_DEG = 270;
   localparam int FULL_TURN_DEG          = 360;

   // atan(2^-i) in degrees, Q16
   localparam int ATAN_TABLE_LEN = 24;
   localparam int ATAN_IDX_WIDTH = $clog2(ATAN_TABLE_LEN);
   localparam logic [21:0] ATAN_DEG_Q16 [ATAN_TABLE_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
      22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
   };

   typedef enum logic {
      OP_TO_POLAR = 1'b0,
      OP_TO_RECT  = 1'b1
   } operation_type;

   // control travelling alongside each datapath stage
   typedef struct packed {
      logic          valid;
      operation_type mode;
      logic          origin;  // rect->polar at x = y = 0
      logic          flip;    // polar->rect, negate rotated vector
   } rpc_ctrl_type;

endpackage

### design/rpc_if.sv
// ----------------------------------------------------------------------------
// rpc_if: request and response channels of the converter
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rpc_req_if #(
   parameter int OPERAND_WIDTH = 11
) ();
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic signed [OPERAND_WIDTH-1:0] first_operand;
   logic signed [OPERAND_WIDTH-1:0] second_operand;

   modport source  (output valid, operation, first_operand, second_operand, input ready);
   modport sink    (input valid, operation, first_operand, second_operand, output ready);
   modport monitor (input valid, ready, operation, first_operand, second_operand);
endinterface

interface rpc_rsp_if import rpc_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [RESULT_WIDTH-1:0] first_result;
   logic signed [RESULT_WIDTH-1:0] second_result;

   modport source  (output valid, first_result, second_result, input ready);
   modport sink    (input valid, first_result, second_result, output ready);
   modport monitor (input valid, ready, first_result, second_result);
endinterface

### design/rect_polar_converter_core.sv
// ----------------------------------------------------------------------------
// rect_polar_converter_core: pipelined CORDIC rectangular/polar converter
// Operand conditioning, a chain of CORDIC cells, gain and rounding stage.
// ----------------------------------------------------------------------------
// Usage
//   req_channel carries one item: operation (0 = rect->polar, 1 = polar->rect)
//   and two signed integer operands (x, y or radius, angle in whole degrees).
//   rsp_channel returns one item per request: radius and angle in degrees
//   (0 to under 360), or x and y; signed, FRACTION_BITS fraction bits.
//   From acceptance to the result being offered an item passes three
//   conditioning stages, one cell per CORDIC stage, the gain multiply
//   stage and the output register. One item a cycle while the receiver
//   takes results, set by the per-stage registers of the cell chain.
//   Each stage holds its own valid bit and moves up whenever the stage
//   below is empty or moving, so bubbles close up while the receiver
//   stalls and req_channel.ready stays high until every stage is full.
//   With rsp_channel.ready held low the output register keeps its item.
//   Synchronous reset empties every stage; no item is offered afterwards
//   until a new one is accepted. Items leave in the order they arrive.
// ----------------------------------------------------------------------------
module rect_polar_converter_core import rpc_pkg::*; #(
   parameter int FRACTION_BITS = 8,
   parameter int CORDIC_STAGES = 16,
   parameter int OPERAND_WIDTH = 11
) (
   input  logic       clock,
   input  logic       reset,
   rpc_req_if.sink    req_channel,
   rpc_rsp_if.source  rsp_channel
);

   // wide enough for r*K in Q30 after the CORDIC growth
   localparam int DATA_WIDTH = OPERAND_WIDTH + GAIN_FRAC + 2;

   // node k sits between the producer of stage k and its consumer
   rpc_ctrl_type                  chain_ctrl  [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0]  chain_x     [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0]  chain_y     [CORDIC_STAGES+1];
   logic signed [ANGLE_WIDTH-1:0] chain_z     [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0]        chain_ready;

   rpc_prep #(
      .OPERAND_WIDTH (OPERAND_WIDTH),
      .DATA_WIDTH    (DATA_WIDTH)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_channel.valid),
      .in_ready     (req_channel.ready),
      .in_operation (req_channel.operation),
      .in_first     (req_channel.first_operand),
      .in_second    (req_channel.second_operand),
      .out_ctrl     (chain_ctrl[0]),
      .out_x        (chain_x[0]),
      .out_y        (chain_y[0]),
      .out_z        (chain_z[0]),
      .out_ready    (chain_ready[0])
   );

   // one micro-rotation per cell, shift and arctangent fixed per position
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      rpc_cordic_cell #(
         .STAGE      (i),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_ctrl    (chain_ctrl[i]),
         .up_x       (chain_x[i]),
         .up_y       (chain_y[i]),
         .up_z       (chain_z[i]),
         .up_ready   (chain_ready[i]),
         .down_ctrl  (chain_ctrl[i+1]),
         .down_x     (chain_x[i+1]),
         .down_y     (chain_y[i+1]),
         .down_z     (chain_z[i+1]),
         .down_ready (chain_ready[i+1])
      );
   end

   rpc_post #(
      .OPERAND_WIDTH (OPERAND_WIDTH),
      .DATA_WIDTH    (DATA_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .up_ctrl    (chain_ctrl[CORDIC_STAGES]),
      .up_x       (chain_x[CORDIC_STAGES]),
      .up_y       (chain_y[CORDIC_STAGES]),
      .up_z       (chain_z[CORDIC_STAGES]),
      .up_ready   (chain_ready[CORDIC_STAGES]),
      .out_valid  (rsp_channel.valid),
      .out_first  (rsp_channel.first_result),
      .out_second (rsp_channel.second_result),
      .out_ready  (rsp_channel.ready)
   );

endmodule

### design/rpc_prep.sv
// ----------------------------------------------------------------------------
// rpc_prep: operand conditioning ahead of the CORDIC chain
// Angle reduction modulo 360, quadrant fold, radius scaling, half-plane turn.
// ----------------------------------------------------------------------------
module rpc_prep import rpc_pkg::*; #(
   parameter int OPERAND_WIDTH = 11,
   parameter int DATA_WIDTH    = 43
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            in_operation,
   input  logic signed [OPERAND_WIDTH-1:0] in_first,
   input  logic signed [OPERAND_WIDTH-1:0] in_second,
   output rpc_ctrl_type                    out_ctrl,
   output logic signed [DATA_WIDTH-1:0]    out_x,
   output logic signed [DATA_WIDTH-1:0]    out_y,
   output logic signed [ANGLE_WIDTH-1:0]   out_z,
   input  logic                            out_ready
);

   localparam int OW = OPERAND_WIDTH;
   localparam int DW = DATA_WIDTH;
   // reciprocal of 360; quotient may come out one low, fixed in stage 2
   localparam int RECIP_SHIFT = OW + 9;
   localparam int RECIP       = (2 ** RECIP_SHIFT) / FULL_TURN_DEG;
   localparam int RW          = $clog2(RECIP + 1);
   localparam logic [RW-1:0] RECIP_W = RW'(RECIP);
   localparam int MW    = OW + 2;
   localparam int DEG_W = 9;
   localparam int RADIUS_W = OW + GAIN_FRAC - 1;

   localparam logic signed [DEG_W:0] DEG_QUARTER = (DEG_W + 1)'(QUARTER_TURN_DEG);
   localparam logic signed [DEG_W:0] DEG_THREE_Q = (DEG_W + 1)'(THREE_QUARTER_TURN_DEG);
   localparam logic signed [DEG_W:0] DEG_HALF    = (DEG_W + 1)'(HALF_TURN_DEG);
   localparam logic signed [DEG_W:0] DEG_FULL    = (DEG_W + 1)'(FULL_TURN_DEG);
   localparam logic signed [ANGLE_WIDTH-1:0] Z_HALF_TURN =
      ANGLE_WIDTH'(HALF_TURN_DEG * (2 ** ANGLE_FRAC));

   // stage 1: magnitude of angle and estimated quotient
   logic                   s1_valid_ff;
   logic                   s1_ready;
   logic                   s1_op_ff;
   logic signed [OW-1:0]   s1_first_ff;
   logic signed [OW-1:0]   s1_second_ff;
   logic                   s1_neg_ff;
   logic [OW-1:0]          s1_mag_ff;
   logic [OW-1:0]          s1_quot_ff;
   logic [OW-1:0]          mag_in;
   logic [OW+RW-1:0]       scaled;
   logic [OW-1:0]          quot_in;

   // stage 2: angle reduced into 0..359
   logic                   s2_valid_ff;
   logic                   s2_ready;
   logic                   s2_op_ff;
   logic signed [OW-1:0]   s2_first_ff;
   logic signed [OW-1:0]   s2_second_ff;
   logic [DEG_W-1:0]       s2_deg_ff;
   logic [MW-1:0]          rem_raw;
   logic [MW-1:0]          rem_fix;
   logic [DEG_W-1:0]       deg_in;

   // stage 3: initial CORDIC vector
   rpc_ctrl_type           s3_ctrl_ff;
   rpc_ctrl_type           ctrl_in;
   logic                   s3_ready;
   logic signed [DW-1:0]   s3_x_ff, s3_y_ff;
   logic signed [ANGLE_WIDTH-1:0] s3_z_ff;
   logic signed [DW-1:0]   x_in, y_in;
   logic signed [ANGLE_WIDTH-1:0] z_in;
   logic signed [DW-1:0]   x_scaled;
   logic [OW-2:0]          radius;
   logic [RADIUS_W-1:0]    rot_mag;
   logic signed [DEG_W:0]  deg_s;
   logic signed [DEG_W:0]  deg_f;
   logic                   flip;

   assign s3_ready = !s3_ctrl_ff.valid || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign mag_in  = in_second[OW-1] ? $unsigned(-in_second) : $unsigned(in_second);
   assign scaled  = (OW + RW)'(mag_in) * (OW + RW)'(RECIP_W);
   assign quot_in = OW'(scaled >> RECIP_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
      if (s1_ready) begin
         s1_op_ff     <= in_operation;
         s1_first_ff  <= in_first;
         s1_second_ff <= in_second;
         s1_neg_ff    <= in_second[OW-1];
         s1_mag_ff    <= mag_in;
         s1_quot_ff   <= quot_in;
      end
   end

   always_comb begin
      rem_raw = MW'(s1_mag_ff) - MW'(s1_quot_ff) * MW'(FULL_TURN_DEG);
      rem_fix = (rem_raw >= MW'(FULL_TURN_DEG)) ? rem_raw - MW'(FULL_TURN_DEG) : rem_raw;
      // negative angles: C-style remainder then lift into 0..359
      if (s1_neg_ff && (rem_fix != '0)) begin
         deg_in = DEG_W'(MW'(FULL_TURN_DEG) - rem_fix);
      end else begin
         deg_in = DEG_W'(rem_fix);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready) begin
         s2_op_ff     <= s1_op_ff;
         s2_first_ff  <= s1_first_ff;
         s2_second_ff <= s1_second_ff;
         s2_deg_ff    <= deg_in;
      end
   end

   always_comb begin
      // quadrant fold into -90..90
      deg_s = $signed({1'b0, s2_deg_ff});
      flip  = 1'b0;
      if ((deg_s > DEG_QUARTER) && (deg_s <= DEG_THREE_Q)) begin
         deg_f = deg_s - DEG_HALF;
         flip  = 1'b1;
      end else if (deg_s > DEG_THREE_Q) begin
         deg_f = deg_s - DEG_FULL;
      end else begin
         deg_f = deg_s;
      end

      radius   = s2_first_ff[OW-1] ? '0 : s2_first_ff[OW-2:0];
      rot_mag  = RADIUS_W'(radius) * RADIUS_W'(CORDIC_GAIN);
      x_scaled = DW'(s2_first_ff) <<< ANGLE_FRAC;

      ctrl_in.valid  = s2_valid_ff;
      ctrl_in.mode   = operation_type'(s2_op_ff);
      ctrl_in.origin = 1'b0;
      ctrl_in.flip   = 1'b0;

      if (ctrl_in.mode == OP_TO_RECT) begin
         x_in         = DW'($signed({1'b0, rot_mag}));
         y_in         = '0;
         z_in         = ANGLE_WIDTH'(deg_f) <<< ANGLE_FRAC;
         ctrl_in.flip = flip;
      end else begin
         ctrl_in.origin = (s2_first_ff == '0) && (s2_second_ff == '0);
         y_in           = DW'(s2_second_ff) <<< ANGLE_FRAC;
         // left half plane: turn by 180 degrees first
         if (s2_first_ff[OW-1]) begin
            x_in = -x_scaled;
            y_in = -y_in;
            z_in = Z_HALF_TURN;
         end else begin
            x_in = x_scaled;
            z_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctrl_ff <= '0;
      end else if (s3_ready) begin
         s3_ctrl_ff <= ctrl_in;
      end
      if (s3_ready) begin
         s3_x_ff <= x_in;
         s3_y_ff <= y_in;
         s3_z_ff <= z_in;
      end
   end

   assign out_ctrl = s3_ctrl_ff;
   assign out_x    = s3_x_ff;
   assign out_y    = s3_y_ff;
   assign out_z    = s3_z_ff;

endmodule

### design/rpc_cordic_cell.sv
// ----------------------------------------------------------------------------
// rpc_cordic_cell: one CORDIC micro-rotation with its pipeline register
// Vectoring steers on the sign of y, rotation on the sign of z.
// ----------------------------------------------------------------------------
module rpc_cordic_cell import rpc_pkg::*; #(
   parameter int STAGE      = 0,
   parameter int DATA_WIDTH = 43
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rpc_ctrl_type                  up_ctrl,
   input  logic signed [DATA_WIDTH-1:0]  up_x,
   input  logic signed [DATA_WIDTH-1:0]  up_y,
   input  logic signed [ANGLE_WIDTH-1:0] up_z,
   output logic                          up_ready,
   output rpc_ctrl_type                  down_ctrl,
   output logic signed [DATA_WIDTH-1:0]  down_x,
   output logic signed [DATA_WIDTH-1:0]  down_y,
   output logic signed [ANGLE_WIDTH-1:0] down_z,
   input  logic                          down_ready
);

   localparam logic [ATAN_IDX_WIDTH-1:0] TABLE_IDX = ATAN_IDX_WIDTH'(STAGE);
   localparam logic signed [ANGLE_WIDTH-1:0] ATAN_STEP =
      ANGLE_WIDTH'(ATAN_DEG_Q16[TABLE_IDX]);

   rpc_ctrl_type                  ctrl_ff;
   logic signed [DATA_WIDTH-1:0]  x_ff, y_ff, x_in, y_in;
   logic signed [ANGLE_WIDTH-1:0] z_ff, z_in;
   logic signed [DATA_WIDTH-1:0]  dx, dy;
   logic                          ccw;

   assign up_ready = !ctrl_ff.valid || down_ready;

   always_comb begin
      dx  = up_y >>> STAGE;
      dy  = up_x >>> STAGE;
      ccw = (up_ctrl.mode == OP_TO_POLAR) ? up_y[DATA_WIDTH-1] : !up_z[ANGLE_WIDTH-1];
      if (ccw) begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - ATAN_STEP;
      end else begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (up_ready) begin
         ctrl_ff <= up_ctrl;
      end
      if (up_ready) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign down_ctrl = ctrl_ff;
   assign down_x    = x_ff;
   assign down_y    = y_ff;
   assign down_z    = z_ff;

endmodule

### design/rpc_post.sv
// ----------------------------------------------------------------------------
// rpc_post: gain compensation, rounding and output register
// Radius scaled by K, angle wrapped into 0 to under 360, vector negated on fold.
// ----------------------------------------------------------------------------
module rpc_post import rpc_pkg::*; #(
   parameter int OPERAND_WIDTH = 11,
   parameter int DATA_WIDTH    = 43,
   parameter int FRACTION_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rpc_ctrl_type                    up_ctrl,
   input  logic signed [DATA_WIDTH-1:0]    up_x,
   input  logic signed [DATA_WIDTH-1:0]    up_y,
   input  logic signed [ANGLE_WIDTH-1:0]   up_z,
   output logic                            up_ready,
   output logic                            out_valid,
   output logic signed [RESULT_WIDTH-1:0]  out_first,
   output logic signed [RESULT_WIDTH-1:0]  out_second,
   input  logic                            out_ready
);

   localparam int DW = DATA_WIDTH;
   // vectoring x fits well inside this width
   localparam int VW = OPERAND_WIDTH + ANGLE_FRAC + 3;
   localparam int PW = VW + GAIN_FRAC + 1;
   localparam int AW = ANGLE_WIDTH + 2;

   localparam int RAD_SHIFT = ANGLE_FRAC + GAIN_FRAC - FRACTION_BITS;
   localparam int ROT_SHIFT = GAIN_FRAC - FRACTION_BITS;
   localparam int ANG_SHIFT = ANGLE_FRAC - FRACTION_BITS;
   localparam int ANG_HALF  = (2 ** ANG_SHIFT) / 2;

   localparam logic signed [PW-1:0] RAD_HALF   = PW'(1) <<< (RAD_SHIFT - 1);
   localparam logic signed [DW-1:0] ROT_HALF   = DW'(1) <<< (ROT_SHIFT - 1);
   localparam logic signed [AW-1:0] ANG_HALF_S = AW'(ANG_HALF);
   localparam logic signed [AW-1:0] FULL_ANG   = AW'(FULL_TURN_DEG) <<< FRACTION_BITS;

   rpc_ctrl_type                  q1_ctrl_ff;
   logic                          q1_ready;
   logic signed [PW-1:0]          q1_prod_ff, prod_in;
   logic signed [DW-1:0]          q1_x_ff, q1_y_ff;
   logic signed [ANGLE_WIDTH-1:0] q1_z_ff;

   logic                          q2_valid_ff;
   logic signed [RESULT_WIDTH-1:0] q2_first_ff, q2_second_ff;
   logic signed [RESULT_WIDTH-1:0] first_in, second_in;
   logic signed [PW-1:0]          rad_sum;
   logic signed [AW-1:0]          ang;
   logic signed [DW-1:0]          x_fl, y_fl, x_sum, y_sum;

   assign q1_ready = !q2_valid_ff || out_ready;
   assign up_ready = !q1_ctrl_ff.valid || q1_ready;

   assign prod_in = PW'($signed(up_x[VW-1:0])) * PW'($signed({1'b0, CORDIC_GAIN}));

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_ctrl_ff <= '0;
      end else if (up_ready) begin
         q1_ctrl_ff <= up_ctrl;
      end
      if (up_ready) begin
         q1_prod_ff <= prod_in;
         q1_x_ff    <= up_x;
         q1_y_ff    <= up_y;
         q1_z_ff    <= up_z;
      end
   end

   always_comb begin
      rad_sum = (q1_prod_ff + RAD_HALF) >>> RAD_SHIFT;

      ang = (AW'(q1_z_ff) + ANG_HALF_S) >>> ANG_SHIFT;
      if (ang < 0) begin
         ang = ang + FULL_ANG;
      end
      if (ang >= FULL_ANG) begin
         ang = ang - FULL_ANG;
      end

      x_fl  = q1_ctrl_ff.flip ? -q1_x_ff : q1_x_ff;
      y_fl  = q1_ctrl_ff.flip ? -q1_y_ff : q1_y_ff;
      x_sum = (x_fl + ROT_HALF) >>> ROT_SHIFT;
      y_sum = (y_fl + ROT_HALF) >>> ROT_SHIFT;

      if (q1_ctrl_ff.mode == OP_TO_RECT) begin
         first_in  = RESULT_WIDTH'(x_sum);
         second_in = RESULT_WIDTH'(y_sum);
      end else if (q1_ctrl_ff.origin) begin
         first_in  = '0;
         second_in = '0;
      end else begin
         first_in  = RESULT_WIDTH'(rad_sum);
         second_in = RESULT_WIDTH'(ang);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q2_valid_ff <= 1'b0;
      end else if (q1_ready) begin
         q2_valid_ff <= q1_ctrl_ff.valid;
      end
      if (q1_ready) begin
         q2_first_ff  <= first_in;
         q2_second_ff <= second_in;
      end
   end

   assign out_valid  = q2_valid_ff;
   assign out_first  = q2_first_ff;
   assign out_second = q2_second_ff;

endmodule

### design/rpc_checker.sv
// ----------------------------------------------------------------------------
// rpc_checker: port-level checks on the converter
// Reset behaviour, output hold under stall, back-pressure relation.
// ----------------------------------------------------------------------------
module rpc_checker import rpc_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [RESULT_WIDTH-1:0] rsp_first_result,
   input logic signed [RESULT_WIDTH-1:0] rsp_second_result
);

   // reset empties the output register
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // a stalled result keeps its value
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_first_result) && $stable(rsp_second_result))
      else $error("stalled result changed or dropped");

   // with the receiver taking items, every stage can move, so input is open
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while output drains");

   // an offered request is taken whenever the receiver is taking items
   a_req_taken: assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_ready |-> req_ready)
      else $error("offered item refused while output drains");

endmodule

bind rect_polar_converter_core rpc_checker u_rpc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_channel.valid),
   .req_ready         (req_channel.ready),
   .rsp_valid         (rsp_channel.valid),
   .rsp_ready         (rsp_channel.ready),
   .rsp_first_result  (rsp_channel.first_result),
   .rsp_second_result (rsp_channel.second_result)
);

### tb/rect_polar_converter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_polar_converter_core_tb: self-checking bench for the CORDIC converter
// Drives coordinate pairs in both directions under random idling on both
// channels. A scoreboard class predicts each result bit for bit and checks
// every result item in order of arrival.
// ----------------------------------------------------------------------------
module rect_polar_converter_core_tb;
   import rpc_pkg::*;

   localparam int FRACTION_BITS = 8;
   localparam int CORDIC_STAGES = 16;
   localparam int OPERAND_WIDTH = 11;

   // acceptance to result offered, counted in pipeline registers
   localparam int PIPE_LATENCY     = CORDIC_STAGES + 5;
   localparam int RANDOM_PER_PHASE = 250;
   // long receiver stall, well beyond the pipeline depth
   localparam int RX_HOLD_CYCLES   = 300;

   typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
   typedef logic signed [RESULT_WIDTH-1:0]  result_t;

   typedef struct packed {
      operation_type operation;
      operand_t      first_operand;
      operand_t      second_operand;
   } request_item;

   typedef struct packed {
      result_t first_result;
      result_t second_result;
   } result_item;

   // -------------------------------------------------------------------------
   // Scoreboard: turns each accepted request into the expected result item
   // and compares result items against them, oldest first.
   // -------------------------------------------------------------------------
   class conversion_scoreboard;
      result_item expected_results[$];
      int         failures;

      // own copy of atan(2^-i) in degrees, Q16
      longint arctan_deg_q16[24] = '{
         2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
         14668, 7334, 3667, 1833, 917, 458, 229, 115,
         57, 29, 14, 7, 4, 2, 1, 0
      };
      longint gain_q30 = 652032874;

      // round half up: add half an LSB, then floor shift
      function longint round_off(longint v, int s);
         return (v + ((longint'(1) <<< s) >>> 1)) >>> s;
      endfunction

      function int stage_count();
         return (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
      endfunction

      // vectoring: (x, y) -> radius, angle in degrees 0 to under 360
      function result_item polar_of(longint x_in, longint y_in);
         longint     x, y, z, dx, dy, rad, ang, full;
         int         i;
         result_item res;
         res = '0;
         if (x_in == 0 && y_in == 0)
            return res;
         x = x_in <<< 16;
         y = y_in <<< 16;
         z = 0;
         // left half plane: turn by a half turn first
         if (x < 0) begin
            x = -x;
            y = -y;
            z = longint'(180) <<< 16;
         end
         for (i = 0; i < stage_count(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
               x = x - dx;
               y = y + dy;
               z = z - arctan_deg_q16[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + arctan_deg_q16[i];
            end
         end
         rad  = round_off(x * gain_q30, 16 + 30 - FRACTION_BITS);
         ang  = round_off(z, 16 - FRACTION_BITS);
         full = longint'(360) <<< FRACTION_BITS;
         if (ang < 0)
            ang = ang + full;
         if (ang >= full)
            ang = ang - full;
         res.first_result  = rad[RESULT_WIDTH-1:0];
         res.second_result = ang[RESULT_WIDTH-1:0];
         return res;
      endfunction

      // rotation: (radius, whole degrees) -> x, y
      function result_item rect_of(longint r, longint deg);
         longint     x, y, z, dx, dy, xo, yo;
         bit         flip;
         int         i;
         result_item res;
         flip = 1'b0;
         if (r < 0)
            r = 0;
         deg = deg % 360;
         if (deg < 0)
            deg = deg + 360;
         if (deg > 90 && deg <= 270) begin
            deg  = deg - 180;
            flip = 1'b1;
         end else if (deg > 270) begin
            deg = deg - 360;
         end
         z = deg <<< 16;
         x = r * gain_q30;
         y = 0;
         for (i = 0; i < stage_count(); i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - arctan_deg_q16[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + arctan_deg_q16[i];
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         xo = round_off(x, 30 - FRACTION_BITS);
         yo = round_off(y, 30 - FRACTION_BITS);
         res.first_result  = xo[RESULT_WIDTH-1:0];
         res.second_result = yo[RESULT_WIDTH-1:0];
         return res;
      endfunction

      function void note_request(request_item req);
         if (req.operation == OP_TO_POLAR)
            expected_results.push_back(polar_of(req.first_operand, req.second_operand));
         else
            expected_results.push_back(rect_of(req.first_operand, req.second_operand));
      endfunction

      function void check_result(result_item got);
         result_item want;
         if (expected_results.size() == 0) begin
            $error("result item with nothing outstanding: first_result %0d second_result %0d",
                   got.first_result, got.second_result);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (got.first_result !== want.first_result) begin
            $error("first_result expected %0d got %0d", want.first_result, got.first_result);
            failures++;
         end
         if (got.second_result !== want.second_result) begin
            $error("second_result expected %0d got %0d", want.second_result, got.second_result);
            failures++;
         end
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpc_req_if #(.OPERAND_WIDTH(OPERAND_WIDTH)) req_channel ();
   rpc_rsp_if                                  rsp_channel ();

   rect_polar_converter_core #(
      .FRACTION_BITS (FRACTION_BITS),
      .CORDIC_STAGES (CORDIC_STAGES),
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .rsp_channel (rsp_channel)
   );

   conversion_scoreboard sb = new();

   // idle chances in percent, changed per phase
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   // set by the stimulus, picked up and counted down by the receiver
   bit rx_hold_request = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("rect_polar_converter_core_tb: errors");
      $finish;
   end

   // Monitor: sample both handshakes at the edge, before any NBA lands.
   always @(posedge clock) begin
      request_item seen_req;
      result_item  seen_rsp;
      if (!reset) begin
         if (req_channel.valid && req_channel.ready) begin
            seen_req.operation      = operation_type'(req_channel.operation);
            seen_req.first_operand  = req_channel.first_operand;
            seen_req.second_operand = req_channel.second_operand;
            sb.note_request(seen_req);
         end
         if (rsp_channel.valid && rsp_channel.ready) begin
            seen_rsp.first_result  = rsp_channel.first_result;
            seen_rsp.second_result = rsp_channel.second_result;
            sb.check_result(seen_rsp);
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   // Exactly one NBA on ready per edge.
   initial begin
      int hold_left;
      rsp_channel.ready = 1'b0;
      forever begin
         if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            for (hold_left = RX_HOLD_CYCLES; hold_left > 0; hold_left--) begin
               rsp_channel.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_channel.ready <= ($urandom_range(99) >= rx_idle_pct);
         @(posedge clock);
      end
   end

   function automatic request_item make_item(operation_type op, int a, int b);
      request_item item;
      item.operation      = op;
      item.first_operand  = operand_t'(a);
      item.second_operand = operand_t'(b);
      return item;
   endfunction

   // Random item: mostly full-range, with bias towards small magnitudes,
   // extremes, axes and angles close to the quadrant boundaries.
   function automatic request_item random_item();
      request_item item;
      int          picks[5] = '{-1024, -1, 0, 1, 1023};
      int          kind;
      kind = $urandom_range(9);
      item.operation      = operation_type'($urandom_range(1));
      item.first_operand  = operand_t'($urandom);
      item.second_operand = operand_t'($urandom);
      case (kind)
         5, 6: begin
            item.first_operand  = operand_t'(int'($urandom_range(32)) - 16);
            item.second_operand = operand_t'(int'($urandom_range(32)) - 16);
         end
         7: begin
            item.first_operand  = operand_t'(picks[$urandom_range(4)]);
            item.second_operand = operand_t'(picks[$urandom_range(4)]);
         end
         8: begin
            // quadrant boundaries, either side, several turns out
            item.operation      = OP_TO_RECT;
            item.first_operand  = operand_t'($urandom_range(1023));
            item.second_operand = operand_t'((int'($urandom_range(22)) - 11) * 90
                                             + int'($urandom_range(2)) - 1);
         end
         9: begin
            if ($urandom_range(1))
               item.first_operand = '0;
            else
               item.second_operand = '0;
         end
         default: ;
      endcase
      return item;
   endfunction

   // Offer one item, idling beforehand at random; returns at the edge where
   // it was taken. Payload is scrambled while valid is low.
   task automatic send_item(request_item item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_channel.valid          <= 1'b0;
         req_channel.operation      <= 1'($urandom_range(1));
         req_channel.first_operand  <= operand_t'($urandom);
         req_channel.second_operand <= operand_t'($urandom);
         @(posedge clock);
      end
      req_channel.valid          <= 1'b1;
      req_channel.operation      <= item.operation;
      req_channel.first_operand  <= item.first_operand;
      req_channel.second_operand <= item.second_operand;
      @(posedge clock);
      while (!req_channel.ready)
         @(posedge clock);
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain_results();
      req_channel.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   task automatic send_random(int count);
      int n;
      for (n = 0; n < count; n++)
         send_item(random_item());
   endtask

   initial begin
      req_channel.valid          = 1'b0;
      req_channel.operation      = OP_TO_POLAR;
      req_channel.first_operand  = '0;
      req_channel.second_operand = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase A: sender idles lightly, receiver heavily
      tx_idle_pct = 27;
      rx_idle_pct = 84;

      // directed: origin, extremes, axes, left half plane, angle wrap
      send_item(make_item(OP_TO_POLAR, 0, 0));
      send_item(make_item(OP_TO_POLAR, 1023, 0));
      send_item(make_item(OP_TO_POLAR, 0, 1023));
      send_item(make_item(OP_TO_POLAR, -1024, 0));
      send_item(make_item(OP_TO_POLAR, 0, -1024));
      send_item(make_item(OP_TO_POLAR, -1024, -1024));
      send_item(make_item(OP_TO_POLAR, 1023, 1023));
      send_item(make_item(OP_TO_POLAR, -1, 0));
      send_item(make_item(OP_TO_POLAR, -5, -3));
      send_item(make_item(OP_TO_POLAR, -5, 3));
      send_item(make_item(OP_TO_POLAR, 3, -5));
      send_item(make_item(OP_TO_POLAR, 1, -1));
      // polar side: negative radius clamps, angles across every branch
      send_item(make_item(OP_TO_RECT, -1, 45));
      send_item(make_item(OP_TO_RECT, -1024, 100));
      send_item(make_item(OP_TO_RECT, 0, 30));
      send_item(make_item(OP_TO_RECT, 1023, 0));
      send_item(make_item(OP_TO_RECT, 1023, 90));
      send_item(make_item(OP_TO_RECT, 1023, 91));
      send_item(make_item(OP_TO_RECT, 1023, 180));
      send_item(make_item(OP_TO_RECT, 1023, 270));
      send_item(make_item(OP_TO_RECT, 1023, 271));
      send_item(make_item(OP_TO_RECT, 1023, 359));
      send_item(make_item(OP_TO_RECT, 1023, 360));
      send_item(make_item(OP_TO_RECT, 1023, -1024));
      send_item(make_item(OP_TO_RECT, 1023, 1023));

      send_random(RANDOM_PER_PHASE);
      drain_results();

      // phase B: roles swapped
      tx_idle_pct = 84;
      rx_idle_pct = 27;
      send_random(RANDOM_PER_PHASE);
      drain_results();

      // phase C: no idling; opens with a long receiver stall so the pipe
      // fills and the block drops req ready
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold_request = 1'b1;
      send_random(RANDOM_PER_PHASE);

      drain_results();
      repeat (PIPE_LATENCY * 4) @(posedge clock);

      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("rect_polar_converter_core_tb: clean");
      end else begin
         $display("rect_polar_converter_core_tb: errors");
      end
      $finish;
   end

endmodule
